// ===== hw/rtl/calendar_date_subtractor_macros.svh =====
// Assertion macros used by calendar_date_subtractor.
`ifndef CALENDAR_DATE_SUBTRACTOR_MACROS_SVH
`define CALENDAR_DATE_SUBTRACTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cds_pkg.sv =====
package cds_pkg;

    localparam int COUNT_BITS = 12;
    // room for count * 10
    localparam int CNT_W      = COUNT_BITS + 4;
    localparam int UPC_W      = 4;

    // floor(a / 25) = (a * LEAP_MUL) >> LEAP_SHIFT for any 16-bit a
    localparam int            LEAP_SHIFT = 24;
    localparam int            MUL_W      = 20;
    localparam logic [19:0]   LEAP_MUL   = 20'd671089;
    localparam int            PROD_W     = 16 + MUL_W;
    localparam int            Q_W        = 12;

    typedef struct packed {
        logic [2:0]         operation;
        logic [11:0]        step_count;
        logic [4:0]         day_in;
        logic [3:0]         month_in;
        logic signed [15:0] year_in;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         day_out;
        logic [3:0]         month_out;
        logic signed [15:0] year_out;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_DAYS    = 3'd0,
        OP_WEEKS   = 3'd1,
        OP_MONTHS  = 3'd2,
        OP_YEARS   = 3'd3,
        OP_DECADES = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_SETN,
        UOP_LEAP_A,
        UOP_LEAP_B,
        UOP_LEAP_C,
        UOP_DAY_DEC,
        UOP_MON_DEC,
        UOP_YR_SUB,
        UOP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_START,
        C_N_ZERO,
        C_DAY_ROLL,
        C_MON_ROLL,
        C_DISPATCH
    } t_cond;

    // microcode addresses
    localparam logic [UPC_W-1:0] UA_IDLE = 4'd0;
    localparam logic [UPC_W-1:0] UA_INIT = 4'd1;
    localparam logic [UPC_W-1:0] UA_LA   = 4'd2;
    localparam logic [UPC_W-1:0] UA_LB   = 4'd3;
    localparam logic [UPC_W-1:0] UA_LC   = 4'd4;
    localparam logic [UPC_W-1:0] UA_DAY  = 4'd5;
    localparam logic [UPC_W-1:0] UA_MON  = 4'd6;
    localparam logic [UPC_W-1:0] UA_YSUB = 4'd7;
    localparam logic [UPC_W-1:0] UA_DONE = 4'd8;

    // next = cond1 ? tgt1 : cond2 ? tgt2 : tgt_else; cond1 C_DISPATCH picks the op's target
    typedef struct packed {
        t_uop              uop;
        t_cond             cond1;
        logic [UPC_W-1:0]  tgt1;
        t_cond             cond2;
        logic [UPC_W-1:0]  tgt2;
        logic [UPC_W-1:0]  tgt_else;
    } t_uword;

    typedef struct packed {
        logic       n_zero;
        logic       day_roll;
        logic       mon_roll;
        logic [2:0] op;
    } t_flags;

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        case (mon)
            4'd2:                      month_days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
            default:                   month_days = 5'd31;
        endcase
    endfunction

    function automatic logic [UPC_W-1:0] dispatch_target(input logic [2:0] op);
        case (op)
            OP_DAYS, OP_WEEKS:    dispatch_target = UA_DAY;
            OP_MONTHS:            dispatch_target = UA_MON;
            OP_YEARS, OP_DECADES: dispatch_target = UA_YSUB;
            default:              dispatch_target = UA_DONE;
        endcase
    endfunction

    function automatic logic cond_true(input t_cond c, input logic start, input t_flags f);
        case (c)
            C_NO_START: cond_true = !start;
            C_N_ZERO:   cond_true = f.n_zero;
            C_DAY_ROLL: cond_true = f.day_roll;
            C_MON_ROLL: cond_true = f.mon_roll;
            default:    cond_true = 1'b0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/cds_urom.sv =====
module cds_urom
    import cds_pkg::*;
(
    input  logic [UPC_W-1:0] i_addr,
    output t_uword           o_word
);

    always_comb begin
        case (i_addr)
            UA_IDLE: o_word = '{UOP_NOP,     C_NO_START, UA_IDLE, C_NEVER,    UA_IDLE, UA_INIT};
            UA_INIT: o_word = '{UOP_SETN,    C_NEVER,    UA_IDLE, C_NEVER,    UA_IDLE, UA_LA};
            UA_LA:   o_word = '{UOP_LEAP_A,  C_NEVER,    UA_IDLE, C_NEVER,    UA_IDLE, UA_LB};
            UA_LB:   o_word = '{UOP_LEAP_B,  C_NEVER,    UA_IDLE, C_NEVER,    UA_IDLE, UA_LC};
            UA_LC:   o_word = '{UOP_LEAP_C,  C_DISPATCH, UA_IDLE, C_NEVER,    UA_IDLE, UA_DONE};
            UA_DAY:  o_word = '{UOP_DAY_DEC, C_N_ZERO,   UA_DONE, C_DAY_ROLL, UA_LA,   UA_DAY};
            UA_MON:  o_word = '{UOP_MON_DEC, C_N_ZERO,   UA_DONE, C_MON_ROLL, UA_LA,   UA_MON};
            UA_YSUB: o_word = '{UOP_YR_SUB,  C_NEVER,    UA_IDLE, C_NEVER,    UA_IDLE, UA_DONE};
            UA_DONE: o_word = '{UOP_EMIT,    C_NEVER,    UA_IDLE, C_NEVER,    UA_IDLE, UA_IDLE};
            default: o_word = '{UOP_NOP,     C_NEVER,    UA_IDLE, C_NEVER,    UA_IDLE, UA_IDLE};
        endcase
    end

endmodule

// ===== hw/rtl/cds_datapath.sv =====
module cds_datapath
    import cds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_load,
    input  t_in_item  i_item,
    input  t_uop      i_uop,
    output t_flags    o_flags,
    output t_out_item o_result
);

    logic [4:0]            r_day,  n_day;
    logic [3:0]            r_mon,  n_mon;
    logic [15:0]           r_yr,   n_yr;
    logic [CNT_W-1:0]      r_n,    n_n;
    logic [COUNT_BITS-1:0] r_cnt,  n_cnt;
    logic [2:0]            r_op,   n_op;
    logic [15:0]           r_abs,  n_abs;
    logic [Q_W-1:0]        r_q,    n_q;
    logic                  r_leap, n_leap;

    logic [PROD_W-1:0]     prod;
    logic [16:0]           q25;
    logic                  div25;
    logic [CNT_W-1:0]      cnt_w;
    logic [3:0]            mon_prev;

    assign cnt_w    = CNT_W'(r_cnt);
    assign prod     = PROD_W'(r_abs) * PROD_W'(LEAP_MUL);
    assign q25      = {1'b0, r_q, 4'b0} + {2'b0, r_q, 3'b0} + 17'(r_q);
    assign div25    = (q25 == {1'b0, r_abs});
    assign mon_prev = r_mon - 4'd1;

    always_comb begin
        n_day  = r_day;
        n_mon  = r_mon;
        n_yr   = r_yr;
        n_n    = r_n;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_abs  = r_abs;
        n_q    = r_q;
        n_leap = r_leap;
        if (i_load) begin
            n_op  = i_item.operation;
            n_cnt = COUNT_BITS'(i_item.step_count);
            n_day = (i_item.day_in == 5'd0) ? 5'd1 : i_item.day_in;
            if (i_item.month_in == 4'd0) begin
                n_mon = 4'd1;
            end else if (i_item.month_in > 4'd12) begin
                n_mon = 4'd12;
            end else begin
                n_mon = i_item.month_in;
            end
            n_yr = i_item.year_in;
        end else begin
            case (i_uop)
                UOP_SETN: begin
                    case (r_op)
                        OP_WEEKS:   n_n = (cnt_w << 3) - cnt_w;
                        OP_DECADES: n_n = (cnt_w << 3) + (cnt_w << 1);
                        default:    n_n = cnt_w;
                    endcase
                end
                UOP_LEAP_A: n_abs = r_yr[15] ? (16'd0 - r_yr) : r_yr;
                UOP_LEAP_B: n_q = prod[LEAP_SHIFT+Q_W-1:LEAP_SHIFT];
                // leap: div by 4 and not 100, or div by 400 (= 16 and 25)
                UOP_LEAP_C: n_leap = (r_abs[1:0] == 2'd0 && !div25) ||
                                     (r_abs[3:0] == 4'd0 && div25);
                UOP_DAY_DEC: begin
                    if (r_n != '0) begin
                        n_n = r_n - CNT_W'(1);
                        if (r_day > 5'd1) begin
                            n_day = r_day - 5'd1;
                        end else if (r_mon == 4'd1) begin
                            n_mon = 4'd12;
                            n_day = 5'd31;
                            n_yr  = r_yr - 16'd1;
                        end else begin
                            n_mon = mon_prev;
                            n_day = month_days(mon_prev, r_leap);
                        end
                    end
                end
                UOP_MON_DEC: begin
                    if (r_n != '0) begin
                        n_n = r_n - CNT_W'(1);
                        if (r_mon == 4'd1) begin
                            // December has 31 days, no clamp needed
                            n_mon = 4'd12;
                            n_yr  = r_yr - 16'd1;
                        end else begin
                            n_mon = mon_prev;
                            if (r_day > month_days(mon_prev, r_leap)) begin
                                n_day = month_days(mon_prev, r_leap);
                            end
                        end
                    end
                end
                UOP_YR_SUB: n_yr = r_yr - 16'(r_n);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_day  <= n_day;
        r_mon  <= n_mon;
        r_yr   <= n_yr;
        r_n    <= n_n;
        r_cnt  <= n_cnt;
        r_op   <= n_op;
        r_abs  <= n_abs;
        r_q    <= n_q;
        r_leap <= n_leap;
    end

    assign o_flags.n_zero   = (r_n == '0);
    assign o_flags.day_roll = (r_day <= 5'd1) && (r_mon == 4'd1);
    assign o_flags.mon_roll = (r_mon == 4'd1);
    assign o_flags.op       = r_op;

    assign o_result.day_out   = r_day;
    assign o_result.month_out = r_mon;
    assign o_result.year_out  = r_yr;

endmodule

// ===== hw/rtl/calendar_date_subtractor.sv =====
// Days, weeks and months step one day or one month at a time until the count is used up;
// each year rollover reruns the 3-step leap-year check. Years and decades subtract the whole
// count in the YR_SUB step; unused operation codes go straight to the done step.
// One transaction in flight: start is taken again in the cycle o_done is high.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset (synchronous, active low) returns the sequencer to idle with no result pending.
module calendar_date_subtractor
    import cds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result
);

`include "calendar_date_subtractor_macros.svh"

    logic [UPC_W-1:0] r_upc, n_upc;
    logic             r_done;
    t_out_item        r_res;
    t_uword           uword;
    t_flags           flags;
    t_out_item        dp_res;
    logic             accept;

    cds_urom u_urom (
        .i_addr (r_upc),
        .o_word (uword)
    );

    cds_datapath u_dp (
        .i_clk    (i_clk),
        .i_load   (accept),
        .i_item   (i_item),
        .i_uop    (uword.uop),
        .o_flags  (flags),
        .o_result (dp_res)
    );

    assign busy   = (r_upc != UA_IDLE);
    assign accept = start && !busy;

    always_comb begin
        if (uword.cond1 == C_DISPATCH) begin
            n_upc = dispatch_target(flags.op);
        end else if (cond_true(uword.cond1, start, flags)) begin
            n_upc = uword.tgt1;
        end else if (cond_true(uword.cond2, start, flags)) begin
            n_upc = uword.tgt2;
        end else begin
            n_upc = uword.tgt_else;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc  <= UA_IDLE;
            r_done <= 1'b0;
        end else begin
            r_upc  <= n_upc;
            r_done <= (uword.uop == UOP_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (uword.uop == UOP_EMIT) begin
            r_res <= dp_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    `CDS_ASSERT_NXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
    `CDS_ASSERT_IMP(a_done_idle, o_done, !busy, "result strobe while sequencer busy")
    `CDS_ASSERT_NXT(a_emit_done, r_upc == UA_DONE, o_done, "done step did not strobe result")
    `CDS_ASSERT_NXT(a_done_single, o_done, !o_done, "result strobe held for two cycles")

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import cds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 4_000_000;
    localparam int          RANDOM_DATES = 75;
    localparam int          SETTLE_CYCLES = 16;
    localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
    localparam logic [2:0]  OP_SPARE_MID = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  i_item  = '0;
    logic      o_done;
    t_out_item o_result;

    t_out_item rewound_dates[$];
    int        cycles = 0;
    int        errors = 0;
    int        dates_sent = 0;
    int        dates_checked = 0;
    int        malformed_sent = 0;

    calendar_date_subtractor dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $realtime,
                     rewound_dates.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_leap(input logic [15:0] yr);
        int sy;
        sy = int'($signed(yr));
        return ((sy % 4 == 0) && (sy % 100 != 0)) || (sy % 400 == 0);
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] mon, input logic [15:0] yr);
        case (mon)
            4'd2:                    return is_leap(yr) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                 return 5'd31;
        endcase
    endfunction

    function automatic t_out_item rewind_date(input t_in_item it);
        logic [4:0]  d;
        logic [3:0]  m;
        logic [15:0] y;
        int          steps;
        t_out_item   res;
        d = it.day_in;
        m = it.month_in;
        y = it.year_in;
        if (m < 4'd1) m = 4'd1;
        if (m > 4'd12) m = 4'd12;
        if (d < 5'd1) d = 5'd1;
        case (it.operation)
            OP_DAYS, OP_WEEKS: begin
                steps = (it.operation == OP_WEEKS) ? int'(it.step_count) * 7
                                                   : int'(it.step_count);
                for (int i = 0; i < steps; i++) begin
                    if (d > 5'd1) begin
                        d = d - 5'd1;
                    end else if (m == 4'd1) begin
                        m = 4'd12;
                        d = 5'd31;
                        y = y - 16'd1;
                    end else begin
                        m = m - 4'd1;
                        d = month_length(m, y);
                    end
                end
            end
            OP_MONTHS: begin
                for (int i = 0; i < int'(it.step_count); i++) begin
                    if (m == 4'd1) begin
                        m = 4'd12;
                        y = y - 16'd1;
                    end else begin
                        m = m - 4'd1;
                    end
                    if (d > month_length(m, y)) d = month_length(m, y);
                end
            end
            OP_YEARS:   y = y - 16'(it.step_count);
            OP_DECADES: y = y - 16'(int'(it.step_count) * 10);
            default: ;
        endcase
        res.day_out   = d;
        res.month_out = m;
        res.year_out  = y;
        return res;
    endfunction

    // ---------------------------------------------------------------- checker

    task automatic flag_field(input string name, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (rewound_dates.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %0d/%0d/%0d with no transaction open",
                         $realtime, o_result.day_out, o_result.month_out,
                         o_result.year_out);
            end else begin
                want = rewound_dates.pop_front();
                dates_checked++;
                if (o_result.day_out !== want.day_out)
                    flag_field("day_out", want.day_out, o_result.day_out);
                if (o_result.month_out !== want.month_out)
                    flag_field("month_out", want.month_out, o_result.month_out);
                if (o_result.year_out !== want.year_out)
                    flag_field("year_out", want.year_out, o_result.year_out);
            end
        end
    end

    // ---------------------------------------------------------------- driver

    // Leaves start high so back-to-back transactions follow without start dropping.
    task automatic issue_date(input t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        rewound_dates.push_back(rewind_date(it));
        dates_sent++;
    endtask

    // Garbage on the item bus while start is low must be ignored.
    task automatic hold_off(input int n);
        start  <= 1'b0;
        i_item <= t_in_item'({$urandom, $urandom});
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_in_item make_date(input logic [2:0] op, input int count,
                                           input int d, input int m, input int y);
        t_in_item it;
        it.operation  = op;
        it.step_count = count[11:0];
        it.day_in     = d[4:0];
        it.month_in   = m[3:0];
        it.year_in    = y[15:0];
        return it;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_count_extremes();
        issue_date(make_date(OP_WEEKS, 4095, 31, 12, 2000));
        issue_date(make_date(OP_DAYS, 4095, 1, 3, -32762));
        issue_date(make_date(OP_MONTHS, 4095, 31, 3, 2024));
        issue_date(make_date(OP_YEARS, 4095, 29, 2, 2024));
        issue_date(make_date(OP_DECADES, 4095, 15, 6, -32768));
        issue_date(make_date(OP_DAYS, 0, 17, 8, 1999));
        hold_off(3);
    endtask

    task automatic test_input_fixups();
        issue_date(make_date(OP_DAYS, 1, 0, 0, 1970));       // month 0 and day 0
        issue_date(make_date(OP_MONTHS, 1, 31, 15, 2023));   // month above 12
        issue_date(make_date(OP_DAYS, 0, 9, 13, -1));
        issue_date(make_date(OP_DAYS, 3, 31, 2, 2023));      // day past month end
        issue_date(make_date(OP_YEARS, 1, 30, 2, 2023));
        issue_date(make_date(OP_SPARE_LO, 4095, 31, 14, 32767));
        issue_date(make_date(OP_SPARE_MID, 4095, 0, 0, -32768));
        issue_date(make_date(OP_SPARE_HI, 4095, 12, 6, 1234));
        hold_off(5);
    endtask

    task automatic test_leap_rules();
        issue_date(make_date(OP_DAYS, 1, 1, 3, 2000));
        issue_date(make_date(OP_DAYS, 1, 1, 3, 1900));
        issue_date(make_date(OP_DAYS, 1, 1, 3, -400));
        issue_date(make_date(OP_DAYS, 1, 1, 3, -100));
        issue_date(make_date(OP_DAYS, 1, 1, 3, -4));
        issue_date(make_date(OP_MONTHS, 1, 31, 3, 2024));
        issue_date(make_date(OP_MONTHS, 3, 31, 5, 2023));   // clamps 30 then 28
        issue_date(make_date(OP_YEARS, 1, 29, 2, 2024));    // Feb 29 survives
        hold_off(2);
    endtask

    task automatic test_year_wrap();
        issue_date(make_date(OP_DAYS, 1, 1, 1, -32768));
        issue_date(make_date(OP_MONTHS, 1, 15, 1, -32768));
        issue_date(make_date(OP_DECADES, 1, 5, 5, -32760));
        hold_off(4);
    endtask

    function automatic int pick_year();
        case ($urandom_range(0, 4))
            0:       return -32768 + int'($urandom_range(0, 20));
            1:       return 32767 - int'($urandom_range(0, 20));
            2:       return (int'($urandom_range(0, 654)) - 327) * 100;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return OP_DAYS;
        if (r < 45) return OP_WEEKS;
        if (r < 70) return OP_MONTHS;
        if (r < 82) return OP_YEARS;
        if (r < 94) return OP_DECADES;
        case ($urandom_range(0, 2))
            0:       return OP_SPARE_LO;
            1:       return OP_SPARE_MID;
            default: return OP_SPARE_HI;
        endcase
    endfunction

    // Mostly valid dates; only every tenth transaction gets a full-range count so run
    // time stays bounded.
    task automatic test_random_traffic();
        int burst;
        int count;
        int d;
        int m;
        int y;
        while (dates_sent < 25 + RANDOM_DATES) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst; b++) begin
                if (dates_sent % 10 == 9) count = $urandom_range(0, 4095);
                else if ($urandom_range(0, 9) < 7) count = $urandom_range(0, 40);
                else count = $urandom_range(41, 600);
                y = pick_year();
                if ($urandom_range(0, 99) < 15) begin
                    malformed_sent++;
                    d = $urandom_range(0, 31);
                    m = $urandom_range(0, 15);
                end else begin
                    m = $urandom_range(1, 12);
                    d = $urandom_range(1, month_length(m[3:0], y[15:0]));
                end
                issue_date(make_date(pick_op(), count, d, m, y));
            end
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 30));
        end
        start <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_count_extremes();
        test_input_fixups();
        test_leap_rules();
        test_year_wrap();
        test_random_traffic();
        while (rewound_dates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d date transactions sent, %0d results checked over all operation codes",
                 dates_sent, dates_checked);
        $display("%0d random transactions carried out-of-range day or month fields",
                 malformed_sent);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
